FILE: rtl/core/fractional_coordinate_wrap_top_assert.svh
// Assertion macros for the fractional coordinate wrap block.
// Used by fractional_coordinate_wrap_top; no other dependencies.
`ifndef FRACTIONAL_COORDINATE_WRAP_TOP_ASSERT_SVH
`define FRACTIONAL_COORDINATE_WRAP_TOP_ASSERT_SVH

// same-cycle implication
`define FCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fcw_pkg.sv
// Shared constants, types and helpers for the fractional coordinate wrap.
// No dependencies.
`timescale 1ns / 1ps

package fcw_pkg;

    localparam int DIMS       = 3;   // active axes, 2 or 3
    localparam int AXES       = 3;
    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 18;
    localparam int ENTRY_BITS = 21;
    localparam int ENTRY_FRAC = 19;
    localparam int ROW_W      = AXES * ENTRY_BITS;
    localparam int PROD_W     = COORD_W + ENTRY_BITS;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SHIFT_W    = SUM_W - ENTRY_FRAC;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_INV_ROW_0   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ROW_1   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ROW_2   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_MSK = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [FRAC_W-1:0]  t_frac;
    typedef logic [ROW_W-1:0]          t_row;

    // stage load enables handed to each axis datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

    // floor divide by 2^ENTRY_FRAC, then clamp to the signed 32-bit range
    function automatic t_coord sat_shift(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] sh;
        sh = s >>> ENTRY_FRAC;
        if (!sh[SHIFT_W-1] && (sh[SHIFT_W-1:COORD_W-1] != '0))
            return {1'b0, {(COORD_W-1){1'b1}}};
        else if (sh[SHIFT_W-1] && (sh[SHIFT_W-1:COORD_W-1] != '1))
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return sh[COORD_W-1:0];
    endfunction

endpackage

FILE: rtl/core/fcw_axis.sv
// One axis of the inverse box transform: products, sum, floor shift and clamp.
// Three register stages. Depends on fcw_pkg.
`timescale 1ns / 1ps

module fcw_axis import fcw_pkg::*; (
    input  logic     i_clk,
    input  t_pipe_en i_en,
    input  t_coord   i_pos [AXES],
    input  t_row     i_row,
    output t_coord   o_f
);

    logic signed [PROD_W-1:0] r_prod [AXES];
    logic signed [SUM_W-1:0]  r_sum;
    t_coord                   r_f;
    logic signed [SUM_W-1:0]  n_sum;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int j = 0; j < AXES; j++) begin
                if (j < DIMS)
                    r_prod[j] <= i_pos[j]
                               * $signed(i_row[j*ENTRY_BITS +: ENTRY_BITS]);
                else
                    r_prod[j] <= '0;
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < AXES; j++)
            n_sum = n_sum + SUM_W'(r_prod[j]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2)
            r_sum <= n_sum;
        if (i_en.s3)
            r_f <= sat_shift(r_sum);
    end

    assign o_f = r_f;

endmodule

FILE: rtl/core/fractional_coordinate_wrap_top.sv
// Channel  | valid   | stall   | payload
// request  | i_valid | o_stall | i_pos_x/y/z, i_vel_x/y/z, i_has_velocity
// result   | o_valid | i_stall | o_frac_x/y/z, o_new_vel_x/y/z
// Four register stages: multiply, sum, floor/clamp, fold and output register.
// One request per cycle while o_stall is low; a request passes r_vld1, r_vld2, r_vld3 and r_out_vld to o_valid.
// A stall holds the output register; bubbles still drain so up to four requests queue.
// Synchronous active-low reset clears the valid bits and the config registers.
// Top level of the fractional coordinate wrap. Depends on fcw_pkg and fcw_axis.
`timescale 1ns / 1ps
`include "fractional_coordinate_wrap_top_assert.svh"

module fractional_coordinate_wrap_top import fcw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROW_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_coord               i_pos_x,
    input  t_coord               i_pos_y,
    input  t_coord               i_pos_z,
    input  t_coord               i_vel_x,
    input  t_coord               i_vel_y,
    input  t_coord               i_vel_z,
    input  logic                 i_has_velocity,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_frac                o_frac_x,
    output t_frac                o_frac_y,
    output t_frac                o_frac_z,
    output t_coord               o_new_vel_x,
    output t_coord               o_new_vel_y,
    output t_coord               o_new_vel_z
);

    t_row            r_inv_row [AXES];
    logic [AXES-1:0] r_reflect;

    logic   r_vld1, r_vld2, r_vld3, r_out_vld;
    logic   r_hv1, r_hv2, r_hv3, r_out_hv;
    t_coord r_vel1 [AXES];
    t_coord r_vel2 [AXES];
    t_coord r_vel3 [AXES];
    t_frac  r_out_frac [AXES];
    t_coord r_out_vel [AXES];

    t_frac  n_frac [AXES];
    t_coord n_vel [AXES];

    logic     w_en4;
    t_pipe_en w_en;
    t_coord   w_pos [AXES];
    t_coord   w_f [AXES];

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++)
                r_inv_row[i] <= '0;
            r_reflect <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INV_ROW_0:   r_inv_row[0] <= i_cfg_data;
                REG_INV_ROW_1:   r_inv_row[1] <= i_cfg_data;
                REG_INV_ROW_2:   r_inv_row[2] <= i_cfg_data;
                REG_REFLECT_MSK: r_reflect    <= i_cfg_data[AXES-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or the next stage loads
    assign w_en4   = !r_out_vld || !i_stall;
    assign w_en.s3 = !r_vld3 || w_en4;
    assign w_en.s2 = !r_vld2 || w_en.s3;
    assign w_en.s1 = !r_vld1 || w_en.s2;
    assign o_stall = !w_en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en.s1) r_vld1    <= i_valid;
            if (w_en.s2) r_vld2    <= r_vld1;
            if (w_en.s3) r_vld3    <= r_vld2;
            if (w_en4)   r_out_vld <= r_vld3;
        end
    end

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    always_ff @(posedge i_clk) begin
        if (w_en.s1) begin
            r_hv1     <= i_has_velocity;
            r_vel1[0] <= i_has_velocity ? i_vel_x : '0;
            r_vel1[1] <= i_has_velocity ? i_vel_y : '0;
            r_vel1[2] <= i_has_velocity ? i_vel_z : '0;
        end
        if (w_en.s2) begin
            r_hv2  <= r_hv1;
            r_vel2 <= r_vel1;
        end
        if (w_en.s3) begin
            r_hv3  <= r_hv2;
            r_vel3 <= r_vel2;
        end
        if (w_en4) begin
            r_out_hv   <= r_hv3;
            r_out_frac <= n_frac;
            r_out_vel  <= n_vel;
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        if (g < DIMS) begin : g_on
            fcw_axis u_axis (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_pos (w_pos),
                .i_row (r_inv_row[g]),
                .o_f   (w_f[g])
            );
        end else begin : g_off
            assign w_f[g] = '0;
        end
    end

    // fold: triangle wave on reflecting axes (velocity negated on the falling half), signed remainder on periodic ones
    always_comb begin
        logic [COORD_W:0] mag;
        logic [15:0]      r;
        for (int i = 0; i < AXES; i++) begin
            n_frac[i] = '0;
            n_vel[i]  = r_vel3[i];
            r         = w_f[i][15:0];
            mag       = w_f[i][COORD_W-1] ? -{w_f[i][COORD_W-1], w_f[i]}
                                          : {1'b0, w_f[i]};
            if (i < DIMS) begin
                if (r_reflect[i]) begin
                    if (w_f[i][16]) begin
                        n_frac[i] = t_frac'(18'sd65536 - $signed({2'b00, r}));
                        if (r_hv3)
                            n_vel[i] = (r_vel3[i] == {1'b1, {(COORD_W-1){1'b0}}})
                                     ? {1'b0, {(COORD_W-1){1'b1}}} : -r_vel3[i];
                    end else begin
                        n_frac[i] = $signed({2'b00, r});
                    end
                end else if (w_f[i][COORD_W-1]) begin
                    n_frac[i] = -$signed({2'b00, mag[15:0]});
                end else begin
                    n_frac[i] = $signed({2'b00, mag[15:0]});
                end
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_frac_x    = r_out_frac[0];
    assign o_frac_y    = r_out_frac[1];
    assign o_frac_z    = r_out_frac[2];
    assign o_new_vel_x = r_out_vel[0];
    assign o_new_vel_y = r_out_vel[1];
    assign o_new_vel_z = r_out_vel[2];

    `FCW_ASSERT_NOW(a_no_vel_zero, i_clk, i_rst_n, o_valid && !r_out_hv,
        o_new_vel_x == '0 && o_new_vel_y == '0 && o_new_vel_z == '0,
        "velocity nonzero without has_velocity")
    `FCW_ASSERT_NOW(a_frac_range, i_clk, i_rst_n, o_valid,
        o_frac_x >= -18'sd65536 && o_frac_x <= 18'sd65536,
        "frac_x out of range")
    `FCW_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_valid && !o_stall,
        r_vld1, "accepted request lost at first stage")
    `FCW_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_new_vel_x) && $stable(o_frac_x),
        "stalled result changed")

endmodule

FILE: test/tb_top.sv
// Self-checking bench for fractional_coordinate_wrap_top: directed and randomized requests checked
// against an in-bench wrap predictor. Depends on fcw_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
    import fcw_pkg::*;

    typedef logic signed [63:0] t_wide;

    typedef struct packed {
        t_coord [AXES-1:0] pos;
        t_coord [AXES-1:0] vel;
        logic              has_vel;
    } t_particle;

    typedef struct packed {
        t_frac  [AXES-1:0] frac;
        t_coord [AXES-1:0] vel;
    } t_wrap_res;

    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     DRAIN_CYCLES  = 8;
    localparam int     PHASES        = 14;
    localparam int     PHASE_ITEMS   = 125;
    localparam t_wide  COORD_MAX     = 64'sh7FFF_FFFF;
    localparam t_wide  COORD_MIN     = -64'sh8000_0000;
    localparam t_coord VEL_MAX       = 32'sh7FFF_FFFF;
    localparam t_coord VEL_MIN       = 32'sh8000_0000;
    localparam logic [ENTRY_BITS-1:0] ENTRY_ONE  = 21'h08_0000;
    localparam logic [ENTRY_BITS-1:0] ENTRY_MAXP = 21'h0F_FFFF;
    localparam logic [ENTRY_BITS-1:0] ENTRY_MAXN = 21'h10_0000;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [ROW_W-1:0]     i_cfg_data     = '0;
    logic                 i_valid        = 1'b0;
    logic                 o_stall;
    t_coord               i_pos_x        = '0;
    t_coord               i_pos_y        = '0;
    t_coord               i_pos_z        = '0;
    t_coord               i_vel_x        = '0;
    t_coord               i_vel_y        = '0;
    t_coord               i_vel_z        = '0;
    logic                 i_has_velocity = 1'b0;
    logic                 o_valid;
    logic                 i_stall        = 1'b0;
    t_frac                o_frac_x, o_frac_y, o_frac_z;
    t_coord               o_new_vel_x, o_new_vel_y, o_new_vel_z;

    // predictor copy of the register file
    t_row       inv_rows [AXES];
    logic [2:0] reflect_bits;

    t_particle pending_particles [$];
    t_wrap_res expected_wraps [$];
    t_particle driven;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        mismatches    = 0;
    int        cycles        = 0;

    fractional_coordinate_wrap_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_vel_x        (i_vel_x),
        .i_vel_y        (i_vel_y),
        .i_vel_z        (i_vel_z),
        .i_has_velocity (i_has_velocity),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frac_x       (o_frac_x),
        .o_frac_y       (o_frac_y),
        .o_frac_z       (o_frac_z),
        .o_new_vel_x    (o_new_vel_x),
        .o_new_vel_y    (o_new_vel_y),
        .o_new_vel_z    (o_new_vel_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // fractional coordinates, then fold (reflect) or signed remainder (periodic) per axis
    function automatic t_wrap_res predict_wrap(input t_particle p);
        t_wrap_res                    r;
        t_wide                        acc;
        t_wide                        f;
        t_wide                        mag;
        logic signed [ENTRY_BITS-1:0] e;
        logic [31:0]                  fbits;
        logic [16:0]                  fold;
        t_coord                       v;
        for (int a = 0; a < AXES; a++) begin
            v = p.has_vel ? t_coord'(p.vel[a]) : '0;
            r.frac[a] = '0;
            if (a < DIMS) begin
                acc = '0;
                for (int c = 0; c < DIMS; c++) begin
                    e = inv_rows[a][c*ENTRY_BITS +: ENTRY_BITS];
                    acc += t_wide'(t_coord'(p.pos[c])) * t_wide'(e);
                end
                f = acc >>> ENTRY_FRAC;  // floor
                if (f > COORD_MAX)
                    f = COORD_MAX;
                else if (f < COORD_MIN)
                    f = COORD_MIN;
                fbits = f[31:0];
                if (reflect_bits[a]) begin
                    fold = fbits[16] ? (17'h1_0000 - {1'b0, fbits[15:0]})
                                     : {1'b0, fbits[15:0]};
                    r.frac[a] = t_frac'({1'b0, fold});
                    if (fbits[16] && p.has_vel)
                        v = (v == VEL_MIN) ? VEL_MAX : -v;
                end else if (!f[63]) begin
                    r.frac[a] = t_frac'({2'b00, f[15:0]});
                end else begin
                    mag = -f;
                    r.frac[a] = -t_frac'({2'b00, mag[15:0]});
                end
            end
            r.vel[a] = v;
        end
        return r;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_wraps.push_back(predict_wrap(driven));
            if (!i_valid || !o_stall) begin
                if (pending_particles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    driven = pending_particles.pop_front();
                    i_pos_x        <= driven.pos[0];
                    i_pos_y        <= driven.pos[1];
                    i_pos_z        <= driven.pos[2];
                    i_vel_x        <= driven.vel[0];
                    i_vel_y        <= driven.vel[1];
                    i_vel_z        <= driven.vel[2];
                    i_has_velocity <= driven.has_vel;
                    i_valid        <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (mismatches < 10)
            $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
        mismatches++;
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_wrap_res got;
        t_wrap_res want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
            if (o_valid && !i_stall) begin
                got.frac = {o_frac_z, o_frac_y, o_frac_x};
                got.vel  = {o_new_vel_z, o_new_vel_y, o_new_vel_x};
                if (expected_wraps.size() == 0) begin
                    if (mismatches < 10)
                        $display("MISMATCH: result with no pending request");
                    mismatches++;
                end else begin
                    want = expected_wraps.pop_front();
                    for (int a = 0; a < AXES; a++) begin
                        if (got.frac[a] !== want.frac[a])
                            note_mismatch($sformatf("frac axis %0d", a),
                                          t_frac'(want.frac[a]), t_frac'(got.frac[a]));
                        if (got.vel[a] !== want.vel[a])
                            note_mismatch($sformatf("new_vel axis %0d", a),
                                          want.vel[a], got.vel[a]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_row data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_REFLECT_MSK)
            reflect_bits = data[2:0];
        else
            inv_rows[idx] = data;
    endtask

    task automatic load_config(input t_row r0, input t_row r1, input t_row r2,
                               input logic [2:0] mask);
        write_reg(REG_INV_ROW_0, r0);
        write_reg(REG_INV_ROW_1, r1);
        write_reg(REG_INV_ROW_2, r2);
        write_reg(REG_REFLECT_MSK, t_row'(mask));
    endtask

    task automatic wait_drained();
        while (pending_particles.size() != 0 || i_valid || expected_wraps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_item(input t_coord px, input t_coord py, input t_coord pz,
                             input t_coord vx, input t_coord vy, input t_coord vz,
                             input logic hv);
        t_particle p;
        p.pos     = {pz, py, px};
        p.vel     = {vz, vy, vx};
        p.has_vel = hv;
        pending_particles.push_back(p);
    endtask

    // half plausible inverse box entries, a quarter raw and a quarter zero
    function automatic logic [ENTRY_BITS-1:0] rand_entry();
        logic [ENTRY_BITS-1:0] mag;
        case ($urandom_range(3))
            0: return ENTRY_BITS'($urandom);
            1: return '0;
            default: begin
                mag = ENTRY_BITS'(ENTRY_ONE / $urandom_range(1, 64));
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic t_row rand_row();
        return {rand_entry(), rand_entry(), rand_entry()};
    endfunction

    function automatic t_particle rand_particle();
        t_particle p;
        for (int a = 0; a < AXES; a++) begin
            p.pos[a] = t_coord'($urandom) >>> $urandom_range(15);
            p.vel[a] = ($urandom_range(15) == 0) ? VEL_MIN : t_coord'($urandom);
        end
        p.has_vel = 1'($urandom_range(1));
        return p;
    endfunction

    initial begin
        t_row ident_x;
        t_row ident_y;
        t_row all_maxp;
        t_row all_maxn;
        ident_x  = t_row'(ENTRY_ONE);
        ident_y  = t_row'(ENTRY_ONE) << ENTRY_BITS;
        all_maxp = {3{ENTRY_MAXP}};
        all_maxn = {3{ENTRY_MAXN}};
        for (int a = 0; a < AXES; a++)
            inv_rows[a] = '0;
        reflect_bits = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: x reflecting identity, y periodic identity, z reflecting -2*(x+y+z)
        load_config(ident_x, ident_y, all_maxn, 3'b101);
        push_item(0, 0, 0, 0, 0, 0, 1'b1);
        push_item(32'sh0001_8000, -32'sh0001_4000, 0, VEL_MIN, 5, 7, 1'b1);
        push_item(32'sh0001_8000, -32'sh0001_4000, 0, 11, 22, 33, 1'b0);
        push_item(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, 1'b1);
        push_item(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, 1'b1);
        push_item(-32'sh4000, -32'sh4000, 32'sh4000, 100, -100, VEL_MIN, 1'b1);
        push_item(32'sh0003_0000, 32'sh0002_0000, -32'sh0000_8000, -1, -1, -1, 1'b1);
        push_item(-32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000, 1, 1, 1, 1'b1);
        push_item(32'sh0000_FFFF, -32'sh0000_FFFF, 32'sh0000_0001, 3, 4, 5, 1'b1);
        push_item(-1, 1, -1, VEL_MAX, VEL_MIN, 0, 1'b0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: load_config(all_maxp, all_maxp, all_maxp, 3'b111);
                1: load_config(all_maxn, all_maxn, all_maxn, 3'b000);
                2: load_config('0, '0, '0, 3'b111);
                3: load_config(ident_x, ident_y, t_row'(ENTRY_ONE) << (2*ENTRY_BITS), 3'b010);
                default: load_config(rand_row(), rand_row(), rand_row(), 3'($urandom));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 65; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mid-phase hold: let the pipe run dry before sending more
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    wait_drained();
                pending_particles.push_back(rand_particle());
            end
            wait_drained();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        wait_drained();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
